// ===== src/lkv_pkg.sv =====
package lkv_pkg;

  // Geometry of the cache.
  localparam int ENTRIES     = 16;
  localparam int KEY_WIDTH   = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int CAP_W       = 5;
  localparam int COUNT_W     = $clog2(ENTRIES + 1);

  localparam logic [COUNT_W-1:0] ENTRIES_CNT = COUNT_W'(ENTRIES);
  localparam logic [CAP_W-1:0]   CAP_RESET   = CAP_W'(16);

  // Operation codes carried in the cmd field.
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Request and response payloads.
  typedef struct packed {
    logic                          cmd;
    logic [KEY_WIDTH-1:0]          key;
    logic signed [VALUE_WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    logic                          found;
    logic signed [VALUE_WIDTH-1:0] read_value;
    logic                          evicted;
  } rsp_t;

  // How the chain moves during an update.
  typedef enum logic [1:0] {
    OP_PROMOTE,
    OP_GROW,
    OP_EVICT
  } chain_op_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE,
    ST_UPDATE
  } state_t;

  // Control shared by all cells.
  typedef struct packed {
    logic                 capture;
    logic                 update;
    chain_op_t            op;
    logic [KEY_WIDTH-1:0] cmp_key;
  } cell_ctl_t;

  // Data handed from one cell to the next, toward the least recent end.
  typedef struct packed {
    logic                   valid;
    logic [KEY_WIDTH-1:0]   key;
    logic [VALUE_WIDTH-1:0] value;
    logic                   hit;
    logic [VALUE_WIDTH-1:0] sel;
  } link_t;

endpackage

// ===== src/lkv_cell.sv =====
module lkv_cell (
  input  logic               clk,
  input  logic               rst,
  input  lkv_pkg::cell_ctl_t ctl,
  input  lkv_pkg::link_t     up,
  output lkv_pkg::link_t     down
);

  logic                            valid;
  logic                            match;
  logic [lkv_pkg::KEY_WIDTH-1:0]   key;
  logic [lkv_pkg::VALUE_WIDTH-1:0] value;
  logic                            shift;

  // Decide whether this cell takes its upper neighbor's entry.
  always_comb begin
    case (ctl.op)
      lkv_pkg::OP_PROMOTE: shift = !up.hit;
      lkv_pkg::OP_GROW:    shift = up.valid;
      lkv_pkg::OP_EVICT:   shift = valid;
      default:             shift = 1'b0;
    endcase
  end

  // Valid mark and match flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctl.capture) begin
        match <= valid && (key == ctl.cmp_key);
      end
      if (ctl.update && ctl.op == lkv_pkg::OP_GROW) begin
        valid <= up.valid;
      end
    end
  end

  // Entry payload moves one place down when shifting.
  always_ff @(posedge clk) begin
    if (ctl.update && shift) begin
      key   <= up.key;
      value <= up.value;
    end
  end

  // Pass the entry and the running hit and selected value downward.
  assign down.valid = valid;
  assign down.key   = key;
  assign down.value = value;
  assign down.hit   = up.hit | match;
  assign down.sel   = up.sel | (match ? value : '0);

endmodule

// ===== src/lru_key_value_cache.sv =====
// Fully associative key/value cache with least-recently-used replacement, built as a chain
// of cells with the most recent entry at the head. Each request is a get or a put; every
// request returns exactly one response. On the transfer edge every cell compares its key
// against the request, and on the next edge the chain shifts by one place up to the hit or
// insert point, unless a get misses, while the response is registered. The block takes no
// new request during that update; after it, a request is taken provided the response slot
// is empty or draining. Valid marks clear at reset; there is no clearing pass. Capacity is
// written through the cfg port while the block is idle; 0 acts as 1 and values above the
// entry count act as the entry count.
module lru_key_value_cache (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      req_valid,
  output logic                      req_stall,
  input  lkv_pkg::req_t             req,
  output logic                      rsp_valid,
  input  logic                      rsp_stall,
  output lkv_pkg::rsp_t             rsp,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);

  lkv_pkg::state_t                 state;
  lkv_pkg::state_t                 state_next;
  logic [lkv_pkg::CAP_W-1:0]       capacity;
  logic [lkv_pkg::COUNT_W-1:0]     count;
  logic [lkv_pkg::COUNT_W-1:0]     cap_eff;
  logic                            cmd_r;
  logic [lkv_pkg::KEY_WIDTH-1:0]   key_r;
  logic [lkv_pkg::VALUE_WIDTH-1:0] value_r;
  logic                            req_xfer;
  logic                            full;
  logic                            hit;
  lkv_pkg::cell_ctl_t              ctl;
  lkv_pkg::link_t                  link [lkv_pkg::ENTRIES+1];

  assign req_xfer = req_valid && !req_stall;

  // Next state.
  always_comb begin
    case (state)
      lkv_pkg::ST_IDLE:   state_next = req_xfer ? lkv_pkg::ST_UPDATE : lkv_pkg::ST_IDLE;
      lkv_pkg::ST_UPDATE: state_next = lkv_pkg::ST_IDLE;
      default:            state_next = lkv_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lkv_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Clamp the capacity register to a usable limit.
  always_comb begin
    if (capacity == '0) begin
      cap_eff = lkv_pkg::COUNT_W'(1);
    end else if (int'(capacity) > lkv_pkg::ENTRIES) begin
      cap_eff = lkv_pkg::ENTRIES_CNT;
    end else begin
      cap_eff = lkv_pkg::COUNT_W'(capacity);
    end
  end

  assign full = (count >= cap_eff);
  assign hit  = link[lkv_pkg::ENTRIES].hit;

  // Controller outputs.
  always_comb begin
    req_stall   = 1'b1;
    cfg_ready   = 1'b0;
    ctl.capture = 1'b0;
    ctl.update  = 1'b0;
    ctl.op      = lkv_pkg::OP_PROMOTE;
    ctl.cmp_key = req.key;
    case (state)
      lkv_pkg::ST_IDLE: begin
        req_stall   = rsp_valid && rsp_stall;
        cfg_ready   = 1'b1;
        ctl.capture = req_valid && !(rsp_valid && rsp_stall);
      end
      lkv_pkg::ST_UPDATE: begin
        ctl.update = hit || (cmd_r == lkv_pkg::CMD_PUT);
        if (hit) begin
          ctl.op = lkv_pkg::OP_PROMOTE;
        end else if (full) begin
          ctl.op = lkv_pkg::OP_EVICT;
        end else begin
          ctl.op = lkv_pkg::OP_GROW;
        end
      end
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

  // Capacity register.
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkv_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Request held for the update cycle.
  always_ff @(posedge clk) begin
    if (req_xfer) begin
      cmd_r   <= req.cmd;
      key_r   <= req.key;
      value_r <= req.value;
    end
  end

  // Entry count grows on each insert that does not evict.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.update && ctl.op == lkv_pkg::OP_GROW) begin
      count <= count + lkv_pkg::COUNT_W'(1);
    end
  end

  // Head of the chain: the entry that becomes most recent.
  assign link[0].valid = 1'b1;
  assign link[0].key   = key_r;
  assign link[0].value = (cmd_r == lkv_pkg::CMD_PUT) ? value_r : link[lkv_pkg::ENTRIES].sel;
  assign link[0].hit   = 1'b0;
  assign link[0].sel   = '0;

  // Row of cells, most recent first.
  for (genvar i = 0; i < lkv_pkg::ENTRIES; i++) begin : g_cell
    lkv_cell u_cell (
      .clk  (clk),
      .rst  (rst),
      .ctl  (ctl),
      .up   (link[i]),
      .down (link[i+1])
    );
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (state == lkv_pkg::ST_UPDATE) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == lkv_pkg::ST_UPDATE) begin
      rsp.found      <= hit;
      rsp.read_value <= (hit && cmd_r == lkv_pkg::CMD_GET) ? link[lkv_pkg::ENTRIES].sel : '0;
      rsp.evicted    <= !hit && (cmd_r == lkv_pkg::CMD_PUT) && full;
    end
  end

endmodule

// ===== src/lkv_checker.sv =====
module lkv_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input lkv_pkg::rsp_t rsp
);

  // A stalled response stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

  // Every request transfer yields a response, registered from the update state.
  a_rsp_latency: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |-> ##2 rsp_valid)
    else $error("response missing after request transfer");

  // The block works on one request at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken during an update");

  // A value is only returned for a key that was found, and never with an eviction.
  a_rsp_consistent: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.read_value == '0 || rsp.found) && !(rsp.found && rsp.evicted))
    else $error("inconsistent response fields");

endmodule

bind lru_key_value_cache lkv_checker u_lkv_checker (.*);
